>>> design/bdel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended list: shared definitions
// Capacity, derived widths, operation and status codes, and the command
// record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bdel_pkg;

   // Ring capacity and the widths that follow from it
   localparam int CAPACITY  = 16;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   // Command queue between front end and back end
   localparam int CQ_DEPTH  = 2;
   localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

   // Field widths
   localparam int OPCODE_W  = 3;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_END   = 3'd1,
      OP_REM_FRONT = 3'd2,
      OP_REM_END   = 3'd3,
      OP_LIST_ALL  = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One decoded operation waiting for the back end
   typedef struct packed {
      opcode_type                 op;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

endpackage

>>> design/bdel_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operation and its value.
// ----------------------------------------------------------------------------
interface bdel_req_if import bdel_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic signed [VALUE_W-1:0]  item_value;

   modport source (output valid, opcode, item_value, input ready);
   modport sink   (input valid, opcode, item_value, output ready);
endinterface

>>> design/bdel_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one status result.
// ----------------------------------------------------------------------------
interface bdel_rsp_if import bdel_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [VALUE_W-1:0]  out_value;
   logic                       last_result;

   modport source (output valid, status, out_value, last_result, input ready);
   modport sink   (input valid, status, out_value, last_result, output ready);
endinterface

>>> design/bdel_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts request transactions, decodes the opcode and queues legal
// operations; unused opcodes are taken and dropped.
// ----------------------------------------------------------------------------
module bdel_front import bdel_pkg::*; (
   bdel_req_if.sink  req_bus,
   input  logic      cq_full,
   output logic      cq_push,
   output cmd_type   cq_cmd
);

   logic legal_op;

   // Classify the opcode
   always_comb begin
      case (req_bus.opcode) inside
         OP_INS_FRONT, OP_INS_END, OP_REM_FRONT, OP_REM_END, OP_LIST_ALL: legal_op = 1'b1;
         default: legal_op = 1'b0;
      endcase
   end

   // Take a transaction whenever the queue has room
   assign req_bus.ready = !cq_full;
   assign cq_push       = req_bus.valid && !cq_full && legal_op;
   assign cq_cmd.op     = opcode_type'(req_bus.opcode);
   assign cq_cmd.value  = req_bus.item_value;

endmodule

>>> design/bdel_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of decoded operations between the front end and back end.
// ----------------------------------------------------------------------------
module bdel_cmd_fifo import bdel_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output cmd_type  pop_cmd
);

   cmd_type              slot_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]  fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full      = (fill_ff == CQ_CNT_W'(CQ_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> design/bdel_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Holds the ring store, front index and entry count, executes queued
// operations and drives the response register.
// ----------------------------------------------------------------------------
module bdel_back import bdel_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cq_valid,
   input  cmd_type    cq_cmd,
   output logic       cq_pop,
   bdel_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_LIST = 2'b10
   } back_state_type;

   back_state_type             state_ff, state_in;
   logic [IDX_W-1:0]           front_ff, front_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           pos_ff, pos_in;
   logic signed [VALUE_W-1:0]  entry_store_ff [CAPACITY];

   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;
   logic                       emit_ok;
   logic                       is_full, is_empty;
   logic [CNT_W-1:0]           pos_next;

   // Ring position of base plus offset, wrapped once
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
      if (sum >= (CNT_W + 1)'(CAPACITY)) begin
         sum = sum - (CNT_W + 1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign emit_ok  = !rsp_valid_ff || rsp_bus.ready;
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign pos_next = CNT_W'(pos_ff) + CNT_W'(1);
   assign rd_addr  = (state_ff == BK_LIST) ? ring_add(front_ff, CNT_W'(pos_ff)) : front_ff;

   // Execute one operation, or emit the next listed entry
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      cq_pop        = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         BK_IDLE: begin
            if (cq_valid && emit_ok) begin
               cq_pop        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               case (cq_cmd.op)
                  OP_INS_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        front_in = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_INS_END: begin
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = ring_add(front_ff, count_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_REM_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        front_in = ring_add(front_ff, CNT_W'(1));
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_REM_END: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_LIST_ALL: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rsp_last_in  = (count_ff == CNT_W'(1));
                        if (count_ff != CNT_W'(1)) begin
                           state_in = BK_LIST;
                           pos_in   = IDX_W'(1);
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                  end
               endcase
            end
         end
         BK_LIST: begin
            if (emit_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rd_en         = 1'b1;
               rsp_last_in   = (pos_next == count_ff);
               if (pos_next == count_ff) begin
                  state_in = BK_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload and ring store; a listed entry loads straight from the store
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (rd_en) begin
         rsp_value_ff <= entry_store_ff[rd_addr];
      end else begin
         rsp_value_ff <= rsp_value_in;
      end
      if (wr_en) begin
         entry_store_ff[wr_addr] <= cq_cmd.value;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.out_value   = rsp_value_ff;
   assign rsp_bus.last_result = rsp_last_ff;

endmodule

>>> design/bounded_double_ended_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended list core
// Ring store of signed 32-bit values with insert and remove at both ends
// and an in-order listing of all stored values.
//
//   Channel   Direction  Transaction carries
//   req_bus   in         opcode, item_value
//   rsp_bus   out        status, out_value, last_result
//
// Insert and remove execute in the back end and give one response each.
// List all gives one response per stored entry, paced by the single read of the
// ring store and the response register; an empty list gives one response.
// Unused opcodes are accepted and give no response.
// Reset clears the front index, entry count and queue; store contents are
// undefined until written. A stalled response holds the back end while the
// command queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module bounded_double_ended_list_core import bdel_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bdel_req_if.sink    req_bus,
   bdel_rsp_if.source  rsp_bus
);

   logic     cq_full;
   logic     cq_push;
   cmd_type  cq_push_cmd;
   logic     cq_pop;
   logic     cq_valid;
   cmd_type  cq_pop_cmd;

   // Decode and queue incoming transactions
   bdel_front u_front (
      .req_bus (req_bus),
      .cq_full (cq_full),
      .cq_push (cq_push),
      .cq_cmd  (cq_push_cmd)
   );

   bdel_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_cmd  (cq_push_cmd),
      .full      (cq_full),
      .pop       (cq_pop),
      .not_empty (cq_valid),
      .pop_cmd   (cq_pop_cmd)
   );

   // Execute operations against the ring
   bdel_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cq_valid (cq_valid),
      .cq_cmd   (cq_pop_cmd),
      .cq_pop   (cq_pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
